@@ rtl/cbd_pkg.sv @@
// Shared types and constants of the cascaded 2x2 box downsampler.
package cbd_pkg;

   localparam int MAX_SIDE_DEFAULT     = 2048;
   localparam int MAX_HALVINGS_DEFAULT = 4;

   localparam int CH_W       = 8;
   localparam int SUM_W      = CH_W + 1;
   localparam int SIDE_REG_W = 12;
   localparam int HALV_REG_W = 3;
   localparam int CSR_DATA_W = 12;
   localparam int CSR_IDX_W  = 2;

   localparam logic [SIDE_REG_W-1:0] IMAGE_SIDE_RESET    = SIDE_REG_W'(1024);
   localparam logic [HALV_REG_W-1:0] HALVING_COUNT_RESET = '0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_SIDE    = 2'd0,
      CSR_HALVING_COUNT = 2'd1
   } csr_idx_type;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [SUM_W-1:0] red;
      logic [SUM_W-1:0] green;
      logic [SUM_W-1:0] blue;
   } sums_type;

   typedef struct packed {
      pixel_type pix;
      logic      last;
   } result_type;

endpackage

@@ rtl/cbd_ram.sv @@
// Generic simple dual-port RAM with registered read.
module cbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/cbd_level.sv @@
// One level of the cascade: position counters and, when HALVE is set, left pixel, line buffer bank, 2x2 average.
module cbd_level import cbd_pkg::*; #(
   parameter int MAX_SIDE = MAX_SIDE_DEFAULT,
   parameter int LEVEL    = 0,
   parameter bit HALVE    = 1'b1,
   localparam int CNT_W   = $clog2(MAX_SIDE),
   localparam int SW      = CNT_W + 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          clear,
   input  logic [SW-1:0] side,
   input  logic          is_final,
   input  logic          in_valid,
   input  pixel_type     in_pix,
   output logic          res_valid,
   output result_type    res,
   output logic          nxt_valid,
   output pixel_type     nxt_pix
);

   localparam int RAM_DEPTH = ((MAX_SIDE >> (LEVEL + 1)) > 0) ? (MAX_SIDE >> (LEVEL + 1)) : 1;
   localparam int AW        = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

   logic [CNT_W-1:0] col_ff, col_in;
   logic [CNT_W-1:0] row_ff, row_in;
   logic             res_valid_ff, res_valid_in;
   result_type       res_ff, res_in;

   logic          accept;
   logic [SW-1:0] col_next, row_next, even_side;
   logic          col_wrap, row_wrap, in_area;

   assign accept    = en & in_valid;
   assign col_next  = SW'({1'b0, col_ff}) + SW'(1);
   assign row_next  = SW'({1'b0, row_ff}) + SW'(1);
   assign col_wrap  = (col_next >= side);
   assign row_wrap  = (row_next >= side);
   // odd sides drop the last row and column
   assign even_side = {side[SW-1:1], 1'b0};
   assign in_area   = (SW'({1'b0, col_ff}) < even_side) && (SW'({1'b0, row_ff}) < even_side);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (clear) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? '0 : row_next[CNT_W-1:0];
         end else begin
            col_in = col_next[CNT_W-1:0];
         end
      end
   end

   always_comb begin
      res_valid_in = res_valid_ff;
      res_in       = res_ff;
      if (en) begin
         res_valid_in = accept & is_final;
         res_in.pix   = in_pix;
         res_in.last  = col_wrap & row_wrap;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         res_valid_ff <= res_valid_in;
      end
      res_ff <= res_in;
   end

   assign res_valid = res_valid_ff;
   assign res       = res_ff;

   generate
      if (HALVE) begin : g_halve
         pixel_type hold_ff, hold_in;
         sums_type  pairs_ff, pairs_in;
         logic      b_valid_ff, b_valid_in;
         sums_type  pairs, above;
         logic      work, ram_we, ram_re;
         logic [AW-1:0]    ram_addr;
         logic [SUM_W:0]   sum_r, sum_g, sum_b;
         logic [$bits(sums_type)-1:0] ram_rdata;

         assign work     = accept & ~is_final & in_area & col_ff[0];
         assign ram_we   = work & ~row_ff[0];
         assign ram_re   = work & row_ff[0];
         assign ram_addr = AW'(col_ff >> 1);

         assign pairs.red   = SUM_W'(hold_ff.red)   + SUM_W'(in_pix.red);
         assign pairs.green = SUM_W'(hold_ff.green) + SUM_W'(in_pix.green);
         assign pairs.blue  = SUM_W'(hold_ff.blue)  + SUM_W'(in_pix.blue);

         always_comb begin
            hold_in    = hold_ff;
            pairs_in   = pairs_ff;
            b_valid_in = b_valid_ff;
            if (accept & ~is_final & in_area & ~col_ff[0]) begin
               hold_in = in_pix;
            end
            if (ram_re) begin
               pairs_in = pairs;
            end
            if (en) begin
               b_valid_in = ram_re;
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               hold_ff    <= '0;
               b_valid_ff <= 1'b0;
            end else begin
               hold_ff    <= hold_in;
               b_valid_ff <= b_valid_in;
            end
            pairs_ff <= pairs_in;
         end

         cbd_ram #(
            .WIDTH ($bits(sums_type)),
            .DEPTH (RAM_DEPTH)
         ) u_line_buf (
            .clock (clock),
            .we    (ram_we),
            .waddr (ram_addr),
            .wdata (pairs),
            .re    (ram_re),
            .raddr (ram_addr),
            .rdata (ram_rdata)
         );

         assign above = sums_type'(ram_rdata);
         assign sum_r = (SUM_W + 1)'(above.red)   + (SUM_W + 1)'(pairs_ff.red);
         assign sum_g = (SUM_W + 1)'(above.green) + (SUM_W + 1)'(pairs_ff.green);
         assign sum_b = (SUM_W + 1)'(above.blue)  + (SUM_W + 1)'(pairs_ff.blue);

         assign nxt_valid     = b_valid_ff;
         assign nxt_pix.red   = sum_r[SUM_W:2];
         assign nxt_pix.green = sum_g[SUM_W:2];
         assign nxt_pix.blue  = sum_b[SUM_W:2];
      end else begin : g_tail
         assign nxt_valid = 1'b0;
         assign nxt_pix   = '0;
      end
   endgenerate

endmodule

@@ rtl/cascaded_box_downsample_2x2.sv @@
// Top level: cascade of 2x2 box-filter halvings with config registers and output skid.
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_stall   req_red_in, req_green_in, req_blue_in
//   rsp       out        rsp_valid/rsp_stall   rsp_red_out, rsp_green_out, rsp_blue_out,
//                                              rsp_frame_last
//   csr       in         csr_we                csr_index, csr_wdata
//
// One request per clock while req_stall is low. A pixel moves one level per cycle while
// the skid register is empty; rsp_valid rises from the response register once the final
// level (halving count capped at MAX_HALVINGS) has registered the completing request.
// Each halving level (all but the last) owns a line buffer bank with at most one access per request at that level.
// Synchronous reset clears counters and valids; line buffers are not cleared.
// req_stall rises only while the output skid register is full.
module cascaded_box_downsample_2x2 import cbd_pkg::*; #(
   parameter int MAX_SIDE     = MAX_SIDE_DEFAULT,
   parameter int MAX_HALVINGS = MAX_HALVINGS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CH_W-1:0]       req_red_in,
   input  logic [CH_W-1:0]       req_green_in,
   input  logic [CH_W-1:0]       req_blue_in,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CH_W-1:0]       rsp_red_out,
   output logic [CH_W-1:0]       rsp_green_out,
   output logic [CH_W-1:0]       rsp_blue_out,
   output logic                  rsp_frame_last,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CNT_W = $clog2(MAX_SIDE);
   localparam int SW    = CNT_W + 1;
   localparam int LVL_W = $clog2(MAX_HALVINGS + 1);

   logic [SIDE_REG_W-1:0] side_ff, side_in;
   logic [HALV_REG_W-1:0] halv_ff, halv_in;
   logic [SW-1:0]         eff_side;
   logic [LVL_W-1:0]      eff_levels;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_ff, skid_in;

   logic       en, take, push, pipe_valid;
   result_type pipe_res;

   logic       chain_valid [MAX_HALVINGS + 2];
   pixel_type  chain_pix   [MAX_HALVINGS + 2];
   logic       lvl_res_valid [MAX_HALVINGS + 1];
   result_type lvl_res       [MAX_HALVINGS + 1];

   // config registers
   always_comb begin
      side_in = side_ff;
      halv_in = halv_ff;
      if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_IMAGE_SIDE:    side_in = csr_wdata[SIDE_REG_W-1:0];
            CSR_HALVING_COUNT: halv_in = csr_wdata[HALV_REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= IMAGE_SIDE_RESET;
         halv_ff <= HALVING_COUNT_RESET;
      end else begin
         side_ff <= side_in;
         halv_ff <= halv_in;
      end
   end

   always_comb begin
      if (side_ff == '0) begin
         eff_side = SW'(1);
      end else if (32'(side_ff) > MAX_SIDE) begin
         eff_side = SW'(MAX_SIDE);
      end else begin
         eff_side = SW'(side_ff);
      end
      if (32'(halv_ff) > MAX_HALVINGS) begin
         eff_levels = LVL_W'(MAX_HALVINGS);
      end else begin
         eff_levels = LVL_W'(halv_ff);
      end
   end

   assign en        = ~skid_valid_ff;
   assign req_stall = skid_valid_ff;

   assign chain_valid[0]     = req_valid;
   assign chain_pix[0].red   = req_red_in;
   assign chain_pix[0].green = req_green_in;
   assign chain_pix[0].blue  = req_blue_in;

   genvar lv;
   generate
      for (lv = 0; lv <= MAX_HALVINGS; lv++) begin : g_level
         cbd_level #(
            .MAX_SIDE (MAX_SIDE),
            .LEVEL    (lv),
            .HALVE    (lv < MAX_HALVINGS)
         ) u_level (
            .clock     (clock),
            .reset     (reset),
            .en        (en),
            .clear     (csr_we),
            .side      (eff_side >> lv),
            .is_final  (eff_levels == LVL_W'(lv)),
            .in_valid  (chain_valid[lv]),
            .in_pix    (chain_pix[lv]),
            .res_valid (lvl_res_valid[lv]),
            .res       (lvl_res[lv]),
            .nxt_valid (chain_valid[lv + 1]),
            .nxt_pix   (chain_pix[lv + 1])
         );
      end
   endgenerate

   assign pipe_valid = lvl_res_valid[eff_levels];
   assign pipe_res   = lvl_res[eff_levels];

   // response register plus skid
   assign take = rsp_valid_ff & ~rsp_stall;
   assign push = en & pipe_valid;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (~rsp_valid_ff | take) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = push;
            rsp_in       = pipe_res;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = pipe_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red_out    = rsp_ff.pix.red;
   assign rsp_green_out  = rsp_ff.pix.green;
   assign rsp_blue_out   = rsp_ff.pix.blue;
   assign rsp_frame_last = rsp_ff.last;

endmodule

@@ tb/sv/downsample_checker.sv @@
`timescale 1ns / 1ps
// Checker: predicts the reduced pixels of each request and compares them with the responses.
module downsample_checker import cbd_pkg::*; #(
   parameter int MAX_SIDE     = MAX_SIDE_DEFAULT,
   parameter int MAX_HALVINGS = MAX_HALVINGS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [CH_W-1:0]       req_red_in,
   input  logic [CH_W-1:0]       req_green_in,
   input  logic [CH_W-1:0]       req_blue_in,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [CH_W-1:0]       rsp_red_out,
   input  logic [CH_W-1:0]       rsp_green_out,
   input  logic [CH_W-1:0]       rsp_blue_out,
   input  logic                  rsp_frame_last,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    errors,
   output int                    outstanding
);

   logic [SIDE_REG_W-1:0] side_reg;
   logic [HALV_REG_W-1:0] halvings_reg;
   sums_type              line_sums [MAX_SIDE];
   pixel_type             held_left [MAX_HALVINGS];
   int unsigned           col_pos [MAX_HALVINGS+1];
   int unsigned           row_pos [MAX_HALVINGS+1];
   result_type            expected_pixels [$];
   int                    mismatch_count = 0;

   assign errors = mismatch_count;

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("%0t checker: %s", $time, msg);
   endtask

   function automatic logic [CH_W-1:0] box_average(logic [SUM_W-1:0] above,
                                                    logic [SUM_W-1:0] below);
      int unsigned total;
      total = above;
      total += below;
      return CH_W'(total / 4);
   endfunction

   task automatic clear_positions();
      for (int i = 0; i <= MAX_HALVINGS; i++) begin
         col_pos[i] = 0;
         row_pos[i] = 0;
      end
   endtask

   // Walks one pixel down the cascade; a level that completes a 2x2 block hands
   // its average to the next level in the same call.
   task automatic predict_reduced_pixel(input pixel_type px, output bit emitted,
                                        output result_type res);
      int unsigned lvl, levels, side, half, c, r, addr;
      pixel_type   cur;
      sums_type    pair, above;
      bit          done;
      levels  = (halvings_reg > MAX_HALVINGS) ? MAX_HALVINGS : halvings_reg;
      side    = (side_reg == 0) ? 1 : ((side_reg > MAX_SIDE) ? MAX_SIDE : side_reg);
      lvl     = 0;
      cur     = px;
      emitted = 1'b0;
      res     = '0;
      done    = 1'b0;
      while (!done) begin
         c    = col_pos[lvl];
         r    = row_pos[lvl];
         half = side / 2;
         if (c + 1 >= side) begin
            col_pos[lvl] = 0;
            row_pos[lvl] = (r + 1 >= side) ? 0 : r + 1;
         end else begin
            col_pos[lvl] = c + 1;
         end
         if (lvl == levels) begin
            res.pix  = cur;
            res.last = (c + 1 >= side) && (r + 1 >= side);
            emitted  = 1'b1;
            done     = 1'b1;
         end else if (c >= 2 * half || r >= 2 * half) begin
            done = 1'b1;  // odd side: last row and column are dropped
         end else if (c % 2 == 0) begin
            held_left[lvl] = cur;
            done = 1'b1;
         end else begin
            pair.red   = {1'b0, held_left[lvl].red}   + {1'b0, cur.red};
            pair.green = {1'b0, held_left[lvl].green} + {1'b0, cur.green};
            pair.blue  = {1'b0, held_left[lvl].blue}  + {1'b0, cur.blue};
            addr = MAX_SIDE - (MAX_SIDE >> lvl) + c / 2;
            if (addr >= MAX_SIDE) begin
               done = 1'b1;
            end else if (r % 2 == 0) begin
               line_sums[addr] = pair;
               done = 1'b1;
            end else begin
               above     = line_sums[addr];
               cur.red   = box_average(above.red, pair.red);
               cur.green = box_average(above.green, pair.green);
               cur.blue  = box_average(above.blue, pair.blue);
               lvl++;
               side = half;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      result_type got;
      bit         emitted;
      if (reset) begin
         side_reg     = IMAGE_SIDE_RESET;
         halvings_reg = HALVING_COUNT_RESET;
         for (int i = 0; i < MAX_HALVINGS; i++) held_left[i] = '0;
         clear_positions();
         expected_pixels.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_IMAGE_SIDE:    side_reg = csr_wdata[SIDE_REG_W-1:0];
               CSR_HALVING_COUNT: halvings_reg = csr_wdata[HALV_REG_W-1:0];
               default: ;
            endcase
            // any write, even to an unused index, restarts the frame
            clear_positions();
         end
         if (rsp_valid && !rsp_stall) begin
            got.pix.red   = rsp_red_out;
            got.pix.green = rsp_green_out;
            got.pix.blue  = rsp_blue_out;
            got.last      = rsp_frame_last;
            if (expected_pixels.size() == 0) begin
               report_mismatch($sformatf("response %h with no request pending", got));
            end else begin
               want = expected_pixels.pop_front();
               if (got.pix.red !== want.pix.red)
                  report_mismatch($sformatf("red got %h want %h", got.pix.red, want.pix.red));
               if (got.pix.green !== want.pix.green)
                  report_mismatch($sformatf("green got %h want %h",
                                            got.pix.green, want.pix.green));
               if (got.pix.blue !== want.pix.blue)
                  report_mismatch($sformatf("blue got %h want %h",
                                            got.pix.blue, want.pix.blue));
               if (got.last !== want.last)
                  report_mismatch($sformatf("frame_last got %b want %b", got.last, want.last));
            end
         end
         if (req_valid && !req_stall) begin
            predict_reduced_pixel(pixel_type'{req_red_in, req_green_in, req_blue_in},
                                  emitted, want);
            if (emitted) expected_pixels.push_back(want);
         end
      end
      outstanding <= expected_pixels.size();
   end

endmodule

@@ tb/sv/tb_cascaded_box_downsample_2x2.sv @@
`timescale 1ns / 1ps
// Testbench top: clock, reset, request stimulus, response stalls and the verdict.
module tb_cascaded_box_downsample_2x2;
   import cbd_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = MAX_HALVINGS_DEFAULT + 6;
   localparam int RANDOM_PIXELS = 550;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [CH_W-1:0]       req_red_in = '0;
   logic [CH_W-1:0]       req_green_in = '0;
   logic [CH_W-1:0]       req_blue_in = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [CH_W-1:0]       rsp_red_out;
   logic [CH_W-1:0]       rsp_green_out;
   logic [CH_W-1:0]       rsp_blue_out;
   logic                  rsp_frame_last;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int          errors;
   int          outstanding;
   bit          sender_idles = 1'b0;
   bit          receiver_idles = 1'b1;
   int unsigned stall_left = 0;
   int unsigned responses_taken = 0;
   int unsigned pixels_sent = 0;
   int unsigned cycle_count = 0;

   cascaded_box_downsample_2x2 u_top (
      .clock, .reset,
      .req_valid, .req_stall, .req_red_in, .req_green_in, .req_blue_in,
      .rsp_valid, .rsp_stall, .rsp_red_out, .rsp_green_out, .rsp_blue_out, .rsp_frame_last,
      .csr_we, .csr_index, .csr_wdata
   );

   downsample_checker u_checker (
      .clock, .reset,
      .req_valid, .req_stall, .req_red_in, .req_green_in, .req_blue_in,
      .rsp_valid, .rsp_stall, .rsp_red_out, .rsp_green_out, .rsp_blue_out, .rsp_frame_last,
      .csr_we, .csr_index, .csr_wdata,
      .errors, .outstanding
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Response side: after each taken response, rsp_stall may be raised at random; the
   // stalling itself switches on and off in stretches.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            responses_taken++;
            if (responses_taken % 24 == 0) receiver_idles = $urandom_range(0, 2) != 0;
            stall_left = receiver_idles ? $urandom_range(0, 7) : 0;
         end else if (stall_left != 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   function automatic logic [CH_W-1:0] random_channel();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return CH_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type p;
      p.red   = random_channel();
      p.green = random_channel();
      p.blue  = random_channel();
      return p;
   endfunction

   // Leaves req_valid high after acceptance so back-to-back requests need no toggle.
   task automatic send_pixel(input pixel_type p);
      int unsigned gap;
      gap = sender_idles ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_red_in   <= p.red;
      req_green_in <= p.green;
      req_blue_in  <= p.blue;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Pixels that produce nothing may still be in the cascade, so give it time.
   task automatic settle();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_format(input int unsigned side, input int unsigned halvings);
      settle();
      write_reg(CSR_IMAGE_SIDE, side);
      write_reg(CSR_HALVING_COUNT, halvings);
   endtask

   task automatic send_random(input int unsigned count);
      for (int unsigned i = 0; i < count; i++) begin
         if ($urandom_range(0, 63) == 0) wait_drained();
         send_pixel(random_pixel());
         pixels_sent++;
      end
   endtask

   initial begin
      int unsigned side, halvings, count, eff;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset format: side 1024, no halving, pixels pass straight through
      send_pixel(pixel_type'{8'h00, 8'h00, 8'h00});
      send_pixel(pixel_type'{8'hFF, 8'hFF, 8'hFF});
      send_pixel(pixel_type'{8'hAA, 8'h55, 8'hAA});
      send_pixel(pixel_type'{8'h55, 8'hAA, 8'h55});

      // one-pixel frames: every pixel is the last of its frame
      set_format(1, 0);
      send_pixel(pixel_type'{8'd12, 8'd34, 8'd56});
      set_format(0, 0);
      send_pixel(pixel_type'{8'hFF, 8'h00, 8'hFF});

      // single 2x2 block, truncating average
      set_format(2, 1);
      send_pixel(pixel_type'{8'd255, 8'd0, 8'd1});
      send_pixel(pixel_type'{8'd255, 8'd0, 8'd2});
      send_pixel(pixel_type'{8'd255, 8'd0, 8'd3});
      send_pixel(pixel_type'{8'd254, 8'd0, 8'd3});

      // odd side drops a row and column; a write to an unused index restarts the frame
      set_format(3, 1);
      for (int i = 0; i < 3; i++) send_pixel(random_pixel());
      settle();
      write_reg(CSR_UNUSED_INDEX, 12'hFFF);
      for (int i = 0; i < 9; i++) send_pixel(random_pixel());

      // oversized side clamps; a side of one reduced once leaves nothing
      set_format(12'hFFF, 0);
      send_pixel(random_pixel());
      send_pixel(random_pixel());
      set_format(1, 1);
      send_pixel(random_pixel());
      send_pixel(random_pixel());

      // deep cascade with an oversized halving count, paused halfway
      set_format(16, 7);
      sender_idles = 1'b1;
      send_random(128);
      wait_drained();
      send_random(128);

      while (pixels_sent < RANDOM_PIXELS) begin
         side = $urandom_range(0, 10);
         if ($urandom_range(0, 7) == 0) begin
            side     = 2048;
            halvings = $urandom_range(0, 1) ? 0 : 4;
            count    = $urandom_range(4, 24);
         end else begin
            halvings = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 7)
                                                   : $urandom_range(0, 3);
            eff   = (side == 0) ? 1 : side;
            count = eff * eff * $urandom_range(1, 3);
            // cut some frames short before the format changes
            if ($urandom_range(0, 3) == 0) count = $urandom_range(1, count);
         end
         if (count > RANDOM_PIXELS - pixels_sent) count = RANDOM_PIXELS - pixels_sent;
         sender_idles = $urandom_range(0, 2) != 0;
         set_format(side, halvings);
         send_random(count);
      end

      settle();
      if (errors == 0 && outstanding == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
